// ===== hdl/bole_pkg.sv =====
package bole_pkg;

    localparam int CAPACITY = 32;
    localparam int VAL_W    = 31;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 6;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        ACT_CLEAR      = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_INSERT_AT  = 3'd3,
        ACT_DELETE     = 3'd4,
        ACT_POP_FRONT  = 3'd5,
        ACT_POP_BACK   = 3'd6,
        ACT_DUMP       = 3'd7
    } act_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_STARTED = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_BAD_POS     = 3'd4,
        ST_FULL        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DUMP,
        S_DELETE
    } state_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CNT_W-1:0]   pos;
        logic [CNT_W-1:0]   count;
        logic [VAL_W-1:0]   value;
    } chain_cmd_t;

endpackage

// ===== hdl/bole_cell.sv =====
module bole_cell (
    input  logic                           clk,
    input  logic [bole_pkg::IDX_W-1:0]     cell_idx,
    input  bole_pkg::chain_cmd_t           cmd,
    input  logic [bole_pkg::VAL_W-1:0]     left_val,
    input  logic [bole_pkg::VAL_W-1:0]     right_val,
    input  logic [bole_pkg::VAL_W-1:0]     head_val,
    output logic [bole_pkg::VAL_W-1:0]     val
);

    logic [bole_pkg::VAL_W-1:0] val_reg;
    logic [bole_pkg::VAL_W-1:0] val_next;
    logic [bole_pkg::CNT_W:0]   idx_ext;
    logic [bole_pkg::CNT_W:0]   idx_plus;
    logic [bole_pkg::CNT_W:0]   pos_ext;
    logic [bole_pkg::CNT_W:0]   cnt_ext;

    assign idx_ext  = (bole_pkg::CNT_W + 1)'(cell_idx);
    assign idx_plus = idx_ext + 1'b1;
    assign pos_ext  = {1'b0, cmd.pos};
    assign cnt_ext  = {1'b0, cmd.count};

    always_comb
    begin
        val_next = val_reg;
        case (cmd.op)
            bole_pkg::CELL_INSERT:
            begin
                // entries at and past the gap move one place back
                if (idx_ext == pos_ext)
                    val_next = cmd.value;
                else if (idx_ext > pos_ext && idx_ext <= cnt_ext)
                    val_next = left_val;
            end
            bole_pkg::CELL_REMOVE:
            begin
                if (idx_ext >= pos_ext && idx_plus < cnt_ext)
                    val_next = right_val;
            end
            bole_pkg::CELL_ROTATE:
            begin
                // head wraps to the tail of the occupied part
                if (idx_plus < cnt_ext)
                    val_next = right_val;
                else if (idx_plus == cnt_ext)
                    val_next = head_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== hdl/bole_ctrl.sv =====
module bole_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     action,
    input  logic [bole_pkg::POS_W-1:0]     position,
    input  logic [bole_pkg::VAL_W-1:0]     element_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [bole_pkg::COUNT_W-1:0]   entry_count_out,
    output logic [bole_pkg::VAL_W-1:0]     dumped_value,
    output logic                           last_of_run,
    input  logic [bole_pkg::VAL_W-1:0]     head_val,
    output bole_pkg::chain_cmd_t           cmd
);

    bole_pkg::state_t           state_reg;
    bole_pkg::state_t           state_next;
    logic [bole_pkg::CNT_W-1:0] count_reg;
    logic [bole_pkg::CNT_W-1:0] count_next;
    logic                       started_reg;
    logic                       started_next;
    logic [bole_pkg::CNT_W-1:0] rem_reg;
    logic [bole_pkg::CNT_W-1:0] rem_next;
    logic                       found_reg;
    logic                       found_next;
    logic [bole_pkg::VAL_W-1:0] target_reg;
    logic [bole_pkg::VAL_W-1:0] target_next;

    logic                       out_valid_reg;
    bole_pkg::status_t          status_reg;
    logic [bole_pkg::CNT_W-1:0] count_out_reg;
    logic [bole_pkg::VAL_W-1:0] value_out_reg;
    logic                       last_reg;

    logic                       emit;
    bole_pkg::status_t          emit_status;
    logic [bole_pkg::VAL_W-1:0] emit_value;
    logic                       emit_last;

    logic                       accept;
    logic                       slot_free;
    logic                       last_step;
    logic                       is_empty;
    logic                       is_full;
    logic                       bad_pos;
    bole_pkg::act_t             act;

    assign act       = bole_pkg::act_t'(action);
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != bole_pkg::S_IDLE) || !slot_free;
    assign accept    = in_valid && !in_stall;
    assign last_step = (rem_reg == bole_pkg::CNT_W'(1));
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg >= bole_pkg::CNT_W'(bole_pkg::CAPACITY));
    assign bad_pos   = bole_pkg::CMP_W'(position) > bole_pkg::CMP_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bole_pkg::S_IDLE:
            begin
                if (accept && act != bole_pkg::ACT_CLEAR && started_reg && !is_empty)
                begin
                    if (act == bole_pkg::ACT_DUMP)
                        state_next = bole_pkg::S_DUMP;
                    else if (act == bole_pkg::ACT_DELETE)
                        state_next = bole_pkg::S_DELETE;
                end
            end
            bole_pkg::S_DUMP,
            bole_pkg::S_DELETE:
            begin
                if (last_step && slot_free)
                    state_next = bole_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bole_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op       = bole_pkg::CELL_HOLD;
        cmd.pos      = '0;
        cmd.count    = count_reg;
        cmd.value    = element_value;
        count_next   = count_reg;
        started_next = started_reg;
        rem_next     = rem_reg;
        found_next   = found_reg;
        target_next  = target_reg;
        emit         = 1'b0;
        emit_status  = bole_pkg::ST_OK;
        emit_value   = '0;
        emit_last    = 1'b1;
        unique case (state_reg)
            bole_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (act == bole_pkg::ACT_CLEAR)
                    begin
                        emit         = 1'b1;
                        count_next   = '0;
                        started_next = 1'b1;
                    end
                    else if (!started_reg)
                    begin
                        emit        = 1'b1;
                        emit_status = bole_pkg::ST_NOT_STARTED;
                    end
                    else
                    begin
                        unique case (act)
                            bole_pkg::ACT_PUSH_FRONT,
                            bole_pkg::ACT_PUSH_BACK,
                            bole_pkg::ACT_INSERT_AT:
                            begin
                                emit = 1'b1;
                                if (act == bole_pkg::ACT_INSERT_AT && bad_pos)
                                    emit_status = bole_pkg::ST_BAD_POS;
                                else if (is_full)
                                    emit_status = bole_pkg::ST_FULL;
                                else
                                begin
                                    cmd.op     = bole_pkg::CELL_INSERT;
                                    count_next = count_reg + 1'b1;
                                    if (act == bole_pkg::ACT_PUSH_BACK)
                                        cmd.pos = count_reg;
                                    else if (act == bole_pkg::ACT_INSERT_AT)
                                        cmd.pos = bole_pkg::CNT_W'(position);
                                end
                            end
                            bole_pkg::ACT_POP_FRONT,
                            bole_pkg::ACT_POP_BACK:
                            begin
                                emit = 1'b1;
                                if (is_empty)
                                    emit_status = bole_pkg::ST_EMPTY;
                                else
                                begin
                                    count_next = count_reg - 1'b1;
                                    if (act == bole_pkg::ACT_POP_FRONT)
                                        cmd.op = bole_pkg::CELL_REMOVE;
                                end
                            end
                            bole_pkg::ACT_DELETE,
                            bole_pkg::ACT_DUMP:
                            begin
                                if (is_empty)
                                begin
                                    emit        = 1'b1;
                                    emit_status = bole_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    rem_next    = count_reg;
                                    found_next  = 1'b0;
                                    target_next = element_value;
                                end
                            end
                            default:
                            begin
                                emit = 1'b0;
                            end
                        endcase
                    end
                end
            end
            bole_pkg::S_DUMP:
            begin
                // head goes out, then rotates to the tail
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_value = head_val;
                    emit_last  = last_step;
                    cmd.op     = bole_pkg::CELL_ROTATE;
                    rem_next   = rem_reg - 1'b1;
                end
            end
            bole_pkg::S_DELETE:
            begin
                // each original entry passes the head once; the first match is dropped
                if (!last_step || slot_free)
                begin
                    rem_next = rem_reg - 1'b1;
                    if (!found_reg && head_val == target_reg)
                    begin
                        cmd.op     = bole_pkg::CELL_REMOVE;
                        count_next = count_reg - 1'b1;
                        found_next = 1'b1;
                    end
                    else
                        cmd.op = bole_pkg::CELL_ROTATE;
                    if (last_step)
                    begin
                        emit        = 1'b1;
                        emit_status = found_next ? bole_pkg::ST_OK : bole_pkg::ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bole_pkg::S_IDLE;
            count_reg     <= '0;
            started_reg   <= 1'b0;
            rem_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            started_reg <= started_next;
            rem_reg     <= rem_next;
            found_reg   <= found_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        if (emit)
        begin
            status_reg    <= emit_status;
            count_out_reg <= count_next;
            value_out_reg <= emit_value;
            last_reg      <= emit_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign entry_count_out = bole_pkg::COUNT_W'(count_out_reg);
    assign dumped_value    = value_out_reg;
    assign last_of_run     = last_reg;

endmodule

// ===== hdl/bounded_ordered_list_engine.sv =====
// results: single-result actions answer in the cycle after acceptance; dump gives one
// entry per step and delete by value answers at its last step; both stall the input
// throughput: one single-result transaction per cycle unless a result is held; dump and
// delete rotate the cell chain past its head one step per cycle as the output allows
// reset: asynchronous, clears the entry count, the started flag and output valid;
// entry cells keep whatever they hold and are only read below the entry count
module bounded_ordered_list_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     action,
    input  logic [bole_pkg::POS_W-1:0]     position,
    input  logic [bole_pkg::VAL_W-1:0]     element_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [bole_pkg::COUNT_W-1:0]   entry_count_out,
    output logic [bole_pkg::VAL_W-1:0]     dumped_value,
    output logic                           last_of_run
);

    bole_pkg::chain_cmd_t       cmd;
    logic [bole_pkg::VAL_W-1:0] cell_val [bole_pkg::CAPACITY];

    bole_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .position        (position),
        .element_value   (element_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_count_out (entry_count_out),
        .dumped_value    (dumped_value),
        .last_of_run     (last_of_run),
        .head_val        (cell_val[0]),
        .cmd             (cmd)
    );

    for (genvar i = 0; i < bole_pkg::CAPACITY; i++)
    begin : g_cell
        logic [bole_pkg::VAL_W-1:0] left_val;
        logic [bole_pkg::VAL_W-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_left
            assign left_val = cell_val[i-1];
        end

        if (i == bole_pkg::CAPACITY - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_right
            assign right_val = cell_val[i+1];
        end

        bole_cell u_cell (
            .clk       (clk),
            .cell_idx  (bole_pkg::IDX_W'(i)),
            .cmd       (cmd),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (cell_val[0]),
            .val       (cell_val[i])
        );
    end

endmodule

// ===== hdl/bole_checker.sv =====
module bole_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [2:0]                     action,
    input  logic [bole_pkg::POS_W-1:0]     position,
    input  logic [bole_pkg::VAL_W-1:0]     element_value,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [2:0]                     status,
    input  logic [bole_pkg::COUNT_W-1:0]   entry_count_out,
    input  logic [bole_pkg::VAL_W-1:0]     dumped_value,
    input  logic                           last_of_run
);

    // a held result blocks new transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("transaction taken while a result is held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
            && $stable(entry_count_out) && $stable(dumped_value) && $stable(last_of_run)))
        else $error("stalled result changed");

    // a clear answers on the next edge with an empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == bole_pkg::ACT_CLEAR) |=>
            (out_valid && status == bole_pkg::ST_OK && entry_count_out == '0
             && last_of_run))
        else $error("clear gave a wrong result");

    // failed actions give a single result with no value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != bole_pkg::ST_OK) |-> (last_of_run && dumped_value == '0))
        else $error("error result not final or carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count_out <= bole_pkg::COUNT_W'(bole_pkg::CAPACITY)))
        else $error("entry count beyond capacity");

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (.*);
